// File: rtl/core/wwa_pkg.sv
// Package: shared types, opcodes and outcome codes for the 256-bit ALU.
`default_nettype none
package wwa_pkg;

    localparam int WORD_W  = 256;
    localparam int LIMB_W  = 64;
    localparam int QDEPTH_DEFAULT = 2;

    localparam logic [7:0] OP_ADD = 8'h01;
    localparam logic [7:0] OP_MUL = 8'h02;
    localparam logic [7:0] OP_SUB = 8'h03;
    localparam logic [7:0] OP_DIV = 8'h04;
    localparam logic [7:0] OP_MOD = 8'h06;

    typedef enum logic [1:0] {
        OUT_OK        = 2'd0,
        OUT_UNDERFLOW = 2'd1,
        OUT_UNHANDLED = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_ZERO
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE, S_MUL, S_DIV, S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  req_type;
        logic        enough_operands;
        logic [63:0] top_limb0;
        logic [63:0] top_limb1;
        logic [63:0] top_limb2;
        logic [63:0] top_limb3;
        logic [63:0] second_limb0;
        logic [63:0] second_limb1;
        logic [63:0] second_limb2;
        logic [63:0] second_limb3;
    } req_t;

    typedef struct packed {
        logic [63:0] result_limb0;
        logic [63:0] result_limb1;
        logic [63:0] result_limb2;
        logic [63:0] result_limb3;
        logic [1:0]  outcome;
    } rsp_t;

    // Classified work item between front and back.
    typedef struct packed {
        kind_t        kind;
        logic [1:0]   outcome;
        logic [255:0] a;
        logic [255:0] b;
    } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/wwa_front.sv
// Front part: classify requests and queue them for the execution unit.
`default_nettype none
module wwa_front #(
    parameter int QDEPTH = wwa_pkg::QDEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wwa_pkg::req_t      req,
    output logic               cmd_valid,
    input  wire logic          cmd_take,
    output wwa_pkg::cmd_t      cmd
);
    import wwa_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    cmd_t              mem [QDEPTH];
    logic [AW-1:0]     wptr_reg, rptr_reg;
    logic [AW:0]       cnt_reg;
    cmd_t              cls;
    logic              do_push, do_pop;

    always_comb
    begin
        cls.a = {req.top_limb3, req.top_limb2, req.top_limb1, req.top_limb0};
        cls.b = {req.second_limb3, req.second_limb2, req.second_limb1,
                 req.second_limb0};
        cls.outcome = OUT_OK;
        cls.kind = K_ZERO;
        if (req.req_type != OP_ADD && req.req_type != OP_MUL &&
            req.req_type != OP_SUB && req.req_type != OP_DIV &&
            req.req_type != OP_MOD)
            cls.outcome = OUT_UNHANDLED;
        else if (!req.enough_operands)
            cls.outcome = OUT_UNDERFLOW;
        else if (req.req_type == OP_ADD)
            cls.kind = K_ADD;
        else if (req.req_type == OP_SUB)
            cls.kind = K_SUB;
        else if (req.req_type == OP_MUL)
            cls.kind = K_MUL;
        else if (cls.b == '0)
            cls.kind = K_ZERO;
        else if (req.req_type == OP_DIV)
            cls.kind = K_DIV;
        else
            cls.kind = K_MOD;
    end

    assign full      = (cnt_reg == (AW+1)'(QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd       = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == AW'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == AW'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/wwa_back.sv
// Back part: immediate add/sub, 32x32 partial-product multiply and radix-2 divide.
`default_nettype none
module wwa_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_take,
    input  wwa_pkg::cmd_t      cmd,
    output logic               empty,
    input  wire logic          pop,
    output wwa_pkg::rsp_t      rsp
);
    import wwa_pkg::*;

    state_t        state_reg, state_next;
    kind_t         kind_reg;
    logic [255:0]  a_reg, b_reg, acc_reg, q_reg, r_reg;
    logic [2:0]    i_reg, j_reg;
    logic [7:0]    bit_reg;
    logic [63:0]   prod_reg;
    logic          prod_ok_reg;
    logic [255:0]  res_reg;
    logic [1:0]    out_reg;
    logic          full_reg;

    logic          start, fin;
    logic [31:0]   ai, bj;
    logic [256:0]  rsh, rdif;
    logic [255:0]  shifted;

    // Output slot frees when popped; a new result may land the same cycle.
    logic slot_free;
    assign slot_free = !full_reg || pop;
    assign empty     = !full_reg;
    assign rsp       = {res_reg[63:0], res_reg[127:64], res_reg[191:128],
                        res_reg[255:192], out_reg};

    // Immediate items finish in the idle state without entering a loop.
    logic imm;
    assign imm      = cmd.kind == K_ADD || cmd.kind == K_SUB || cmd.kind == K_ZERO;
    assign start    = state_reg == S_IDLE && cmd_valid && (!imm || slot_free);
    assign cmd_take = start;

    assign ai = a_reg[i_reg*32 +: 32];
    assign bj = b_reg[j_reg*32 +: 32];
    assign rsh  = {r_reg, a_reg[bit_reg]};
    assign rdif = rsh - {1'b0, b_reg};
    assign shifted = rdif[256] ? rsh[255:0] : rdif[255:0];

    // Only the pair (7,0) has i equal to 7.
    logic mul_last;
    assign mul_last = (i_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start && !imm)
                    state_next = (cmd.kind == K_MUL) ? S_MUL : S_DIV;
            S_MUL:
                if (prod_ok_reg && mul_last)
                    state_next = S_DONE;
            S_DIV:
                if (bit_reg == 8'd0)
                    state_next = S_DONE;
            S_DONE:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign fin = state_reg == S_DONE && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            full_reg    <= 1'b0;
            prod_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((start && imm) || fin)
                full_reg <= 1'b1;
            else if (pop)
                full_reg <= 1'b0;
            if (state_reg == S_MUL)
                prod_ok_reg <= !prod_ok_reg;
            else
                prod_ok_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg <= cmd.kind;
            a_reg    <= cmd.a;
            b_reg    <= cmd.b;
            acc_reg  <= '0;
            r_reg    <= '0;
            q_reg    <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            bit_reg  <= 8'd255;
            if (imm)
            begin
                out_reg <= cmd.outcome;
                unique case (cmd.kind)
                    K_ADD:   res_reg <= cmd.a + cmd.b;
                    K_SUB:   res_reg <= cmd.a - cmd.b;
                    default: res_reg <= '0;
                endcase
            end
        end
        // Multiply: one product, then one shifted accumulate, per 32-bit limb pair.
        if (state_reg == S_MUL)
        begin
            if (!prod_ok_reg)
                prod_reg <= ai * bj;
            else
            begin
                acc_reg <= acc_reg + (256'(prod_reg) << (32 * (32'(i_reg) + 32'(j_reg))));
                if (32'(i_reg) + 32'(j_reg) == 7)
                begin
                    i_reg <= i_reg + 3'd1;
                    j_reg <= '0;
                end
                else
                    j_reg <= j_reg + 3'd1;
            end
        end
        // Divide: one quotient bit per cycle.
        if (state_reg == S_DIV)
        begin
            r_reg <= shifted;
            q_reg[bit_reg] <= !rdif[256];
            bit_reg <= bit_reg - 8'd1;
        end
        if (fin)
        begin
            out_reg <= OUT_OK;
            unique case (kind_reg)
                K_MUL:   res_reg <= acc_reg;
                K_DIV:   res_reg <= q_reg;
                default: res_reg <= r_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/wide_word_alu256.sv
// Top level of the 256-bit stack-machine ALU.
`default_nettype none
// Queue-style 256-bit ALU. Push a request while full is low; pop a result
// while empty is low. The front classifies each transfer (opcode check,
// underflow, zero divisor) and holds it in a small queue; the back runs it.
// ADD, SUB, underflow, unhandled opcodes and division by zero finish without
// a loop in the back. MUL steps through thirty-six 32x32 limb products, each a
// product then a shifted accumulate. DIV and MOD run a restoring divider at
// one quotient bit per cycle. The single result register lets a next MUL, DIV
// or MOD item start while a finished result still waits to be popped.
module wide_word_alu256 #(
    parameter int QDEPTH = wwa_pkg::QDEPTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wwa_pkg::req_t req,
    output logic          empty,
    input  wire logic     pop,
    output wwa_pkg::rsp_t rsp
);
    import wwa_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    wwa_front #(.QDEPTH(QDEPTH)) u_front (
        .clk, .rst_n, .push, .full, .req,
        .cmd_valid, .cmd_take, .cmd
    );

    wwa_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
        .empty, .pop, .rsp
    );
endmodule
`default_nettype wire

// File: tb/sv/wide_word_alu256_tb.sv
// Testbench for the 256-bit stack-machine ALU: directed and random requests, scoreboard check.
`default_nettype none
module wide_word_alu256_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wwa_pkg::*;

    // Watchdog limit covers long DIV/MOD runs and receiver stalls.
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;

    rsp_t alu_expected[$];
    int   mismatches;
    int   idle_cycles;
    bit   draining;

    wide_word_alu256 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Compute the expected result word and outcome of one request.
    function automatic rsp_t alu_predict(req_t r);
        logic [255:0] a;
        logic [255:0] b;
        logic [255:0] word;
        logic [511:0] prod;
        rsp_t res;
        a = {r.top_limb3, r.top_limb2, r.top_limb1, r.top_limb0};
        b = {r.second_limb3, r.second_limb2, r.second_limb1, r.second_limb0};
        word = '0;
        res.outcome = OUT_OK;
        if (!(r.req_type inside {OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_MOD}))
            res.outcome = OUT_UNHANDLED;
        else if (!r.enough_operands)
            res.outcome = OUT_UNDERFLOW;
        else
        begin
            case (r.req_type)
                OP_ADD: word = a + b;
                OP_SUB: word = a - b;
                OP_MUL:
                begin
                    prod = {256'b0, a} * {256'b0, b};
                    word = prod[255:0];
                end
                OP_DIV: word = (b == 0) ? '0 : a / b;
                default: word = (b == 0) ? '0 : a % b;
            endcase
        end
        res.result_limb0 = word[63:0];
        res.result_limb1 = word[127:64];
        res.result_limb2 = word[191:128];
        res.result_limb3 = word[255:192];
        return res;
    endfunction

    function automatic logic [63:0] rand_limb();
        return {$urandom, $urandom};
    endfunction

    // Pick a limb from the interesting corners or fully random.
    function automatic logic [63:0] corner_limb();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h1;
            3: return 64'h8000_0000_0000_0000;
            4: return {32'b0, $urandom};
            default: return rand_limb();
        endcase
    endfunction

    function automatic req_t make_req(logic [7:0] op, logic enough,
                                      logic [255:0] a, logic [255:0] b);
        req_t r;
        r.req_type = op;
        r.enough_operands = enough;
        {r.top_limb3, r.top_limb2, r.top_limb1, r.top_limb0} = a;
        {r.second_limb3, r.second_limb2, r.second_limb1, r.second_limb0} = b;
        return r;
    endfunction

    // Present one request and hold it until the transfer happens.
    task automatic send_req(req_t r);
        push <= 1'b1;
        req  <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        alu_expected.push_back(alu_predict(r));
    endtask

    // Drop push for a random gap, sometimes none, to end a burst.
    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_burst(req_t r[$]);
        int left;
        left = $urandom_range(1, 10);
        foreach (r[i])
        begin
            send_req(r[i]);
            left--;
            if (left == 0)
            begin
                sender_gap();
                left = $urandom_range(1, 10);
            end
        end
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        req_t q[$];
        logic [255:0] ones;
        ones = '1;
        q.push_back(make_req(OP_ADD, 1'b1, ones, 256'd1));
        q.push_back(make_req(OP_ADD, 1'b1, ones, ones));
        q.push_back(make_req(OP_ADD, 1'b1, 256'd0, 256'd0));
        q.push_back(make_req(OP_SUB, 1'b1, 256'd0, 256'd1));
        q.push_back(make_req(OP_SUB, 1'b1, ones, ones));
        q.push_back(make_req(OP_MUL, 1'b1, ones, ones));
        q.push_back(make_req(OP_MUL, 1'b1, {64'b0, ones[191:0]}, 256'd0));
        q.push_back(make_req(OP_MUL, 1'b1, {192'b0, 64'hFFFF_FFFF_FFFF_FFFF},
                             {192'b0, 64'hFFFF_FFFF_FFFF_FFFF}));
        q.push_back(make_req(OP_DIV, 1'b1, ones, 256'd0));
        q.push_back(make_req(OP_MOD, 1'b1, ones, 256'd0));
        q.push_back(make_req(OP_DIV, 1'b1, ones, 256'd1));
        q.push_back(make_req(OP_DIV, 1'b1, ones, ones));
        q.push_back(make_req(OP_MOD, 1'b1, ones, 256'd7));
        q.push_back(make_req(OP_DIV, 1'b1, 256'd5, ones));
        q.push_back(make_req(OP_MOD, 1'b1, 256'd5, ones));
        q.push_back(make_req(OP_ADD, 1'b0, ones, ones));
        q.push_back(make_req(OP_MUL, 1'b0, ones, ones));
        q.push_back(make_req(OP_SUB, 1'b0, ones, ones));
        q.push_back(make_req(OP_DIV, 1'b0, ones, ones));
        q.push_back(make_req(OP_MOD, 1'b0, ones, ones));
        q.push_back(make_req(8'h05, 1'b1, ones, 256'd3));
        q.push_back(make_req(8'h07, 1'b1, ones, 256'd3));
        q.push_back(make_req(8'h00, 1'b0, ones, ones));
        q.push_back(make_req(8'hFF, 1'b1, ones, ones));
        send_burst(q);
    endtask

    // Mostly valid requests; DIV/MOD kept rarer since each runs the bit-serial divider.
    task automatic test_random(int count);
        req_t q[$];
        logic [7:0] op;
        logic [255:0] a;
        logic [255:0] b;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      op = OP_ADD;
            else if (pick < 50) op = OP_SUB;
            else if (pick < 72) op = OP_MUL;
            else if (pick < 80) op = OP_DIV;
            else if (pick < 88) op = OP_MOD;
            else                op = 8'($urandom_range(0, 255));
            a = {corner_limb(), corner_limb(), corner_limb(), corner_limb()};
            b = {corner_limb(), corner_limb(), corner_limb(), corner_limb()};
            // Narrow divisors give long quotients; zero divisors still appear.
            if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 2) == 0)
                b = {192'b0, corner_limb()};
            q.push_back(make_req(op, $urandom_range(0, 9) != 0, a, b));
        end
        send_burst(q);
    endtask

    // Receiver: stall on its own pattern, with stall-free stretches.
    initial
    begin
        int phase;
        pop <= 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 256;
            if (phase < 64)
                pop <= 1'b1;
            else if (phase < 128)
                pop <= ($urandom_range(0, 3) != 0);
            else
                pop <= ($urandom_range(0, 40) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        end
    end

    // Check each popped result against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && pop && !empty)
        begin
            if (alu_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h", rsp);
            end
            else
            begin
                want = alu_expected.pop_front();
                if (rsp.result_limb0 !== want.result_limb0 ||
                    rsp.result_limb1 !== want.result_limb1 ||
                    rsp.result_limb2 !== want.result_limb2 ||
                    rsp.result_limb3 !== want.result_limb3 ||
                    rsp.outcome !== want.outcome)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h_%h_%h_%h/%0d got %h_%h_%h_%h/%0d",
                                 want.result_limb3, want.result_limb2, want.result_limb1,
                                 want.result_limb0, want.outcome, rsp.result_limb3,
                                 rsp.result_limb2, rsp.result_limb1, rsp.result_limb0,
                                 rsp.outcome);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n || draining)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        draining = 1'b0;
        rst_n = 1'b0;
        push <= 1'b0;
        req  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1400);
        while (alu_expected.size() != 0)
            @(posedge clk);
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && alu_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
